[rtl/dopc_pkg.sv]
// ----------------------------------------------------------------------------
// dopc_pkg
// Types, codes and field widths shared by the open-page command generator.
// ----------------------------------------------------------------------------
package dopc_pkg;

    localparam int ADDRESS_BITS = 33;
    localparam int TIME_BITS    = 32;
    localparam int ROW_SHIFT    = 18;
    localparam int ROW_W        = ADDRESS_BITS - ROW_SHIFT;
    localparam int RC_W         = 15;
    localparam int COL_W        = 11;
    localparam int BUSY_W       = 11;
    localparam int TCFG_W       = 8;
    localparam int CFG_ADDR_W   = 3;
    localparam int MAX_CMDS     = 3;
    localparam int CNT_W        = 2;

    localparam logic [BUSY_W-1:0] SIMPLE_CYCLES = BUSY_W'(5);

    // request kinds
    typedef enum logic [1:0] {
        REQ_READ    = 2'd0,
        REQ_WRITE   = 2'd1,
        REQ_FETCH   = 2'd2,
        REQ_INVALID = 2'd3
    } req_t;

    // DRAM commands
    typedef enum logic [1:0] {
        CMD_PRE = 2'd0,
        CMD_ACT = 2'd1,
        CMD_RD  = 2'd2,
        CMD_WR  = 2'd3
    } dram_cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_T_RAS   = 3'd0,
        CFG_T_RCD   = 3'd1,
        CFG_T_RP    = 3'd2,
        CFG_T_CAS   = 3'd3,
        CFG_T_BURST = 3'd4,
        CFG_SIMPLE  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [TCFG_W-1:0] t_ras;
        logic [TCFG_W-1:0] t_rcd;
        logic [TCFG_W-1:0] t_rp;
        logic [TCFG_W-1:0] t_cas;
        logic [TCFG_W-1:0] t_burst;
        logic              simple_mode;
    } cfg_t;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           bank;
        logic [ROW_W-1:0]     row;
        logic [TIME_BITS-1:0] act_time;
    } open_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] issue_time;
        dram_cmd_t            dram_command;
        logic [1:0]           bank_group;
        logic [1:0]           bank_index;
        logic [RC_W-1:0]      row_or_column;
        logic                 last_of_request;
        logic [BUSY_W-1:0]    busy_cycles;
    } result_t;

    // command list for one request, entry 0 goes out first
    typedef struct packed {
        result_t [MAX_CMDS-1:0] res;
        logic [CNT_W-1:0]       count;
        logic                   upd;
        open_t                  next_open;
    } plan_t;

endpackage

[rtl/dopc_plan.sv]
// ----------------------------------------------------------------------------
// dopc_plan
// Classifies one request against the open row and builds its command list
// with timestamps, busy cycles and the next open-row state.
// ----------------------------------------------------------------------------
module dopc_plan (
    input  logic [1:0]                       command,
    input  logic [dopc_pkg::ADDRESS_BITS-1:0] address,
    input  logic [dopc_pkg::TIME_BITS-1:0]    now_time,
    input  dopc_pkg::cfg_t                   cfg,
    input  dopc_pkg::open_t                  open_st,
    output dopc_pkg::plan_t                  plan
);

    logic [1:0]                        bg;
    logic [1:0]                        bk;
    logic [dopc_pkg::COL_W-1:0]        col;
    logic [dopc_pkg::RC_W-1:0]         col_rc;
    logic [dopc_pkg::ROW_W-1:0]        row;
    logic [dopc_pkg::RC_W-1:0]         row_rc;
    dopc_pkg::dram_cmd_t               acc;
    logic                              row_hit;
    logic [dopc_pkg::TIME_BITS-1:0]    elapsed;
    logic                              in_ras;
    logic [dopc_pkg::TCFG_W-1:0]       wait_cyc;
    logic [dopc_pkg::TCFG_W:0]         off_act;
    logic [dopc_pkg::TCFG_W+1:0]       off_acc;
    logic [dopc_pkg::TCFG_W:0]         cas_burst;
    logic [dopc_pkg::TIME_BITS-1:0]    t_pre;
    logic [dopc_pkg::TIME_BITS-1:0]    t_act;
    logic [dopc_pkg::TIME_BITS-1:0]    t_acc_miss;
    logic [dopc_pkg::TIME_BITS-1:0]    t_acc_hit;
    dopc_pkg::result_t                 r_pre;
    dopc_pkg::result_t                 r_act;
    dopc_pkg::result_t                 r_acc;

    assign bg      = address[7:6];
    assign bk      = address[9:8];
    assign col     = {address[17:10], address[5:3]};
    assign col_rc  = dopc_pkg::RC_W'(col);
    assign row     = address[dopc_pkg::ADDRESS_BITS-1:dopc_pkg::ROW_SHIFT];
    assign row_rc  = dopc_pkg::RC_W'(row);
    assign acc     = (dopc_pkg::req_t'(command) == dopc_pkg::REQ_WRITE) ?
                     dopc_pkg::CMD_WR : dopc_pkg::CMD_RD;
    assign row_hit = open_st.valid && (row == open_st.row);

    // remaining tRAS since the last activate, modulo the time width
    assign elapsed  = now_time - open_st.act_time;
    assign in_ras   = open_st.valid
                   && (elapsed[dopc_pkg::TIME_BITS-1:dopc_pkg::TCFG_W] == '0)
                   && (elapsed[dopc_pkg::TCFG_W-1:0] < cfg.t_ras);
    assign wait_cyc = in_ras ? (cfg.t_ras - elapsed[dopc_pkg::TCFG_W-1:0]) : '0;

    assign off_act   = {1'b0, wait_cyc} + {1'b0, cfg.t_rp};
    assign off_acc   = {1'b0, off_act} + {2'b00, cfg.t_rcd};
    assign cas_burst = {1'b0, cfg.t_cas} + {1'b0, cfg.t_burst};

    assign t_pre      = now_time + dopc_pkg::TIME_BITS'(wait_cyc);
    assign t_act      = now_time + dopc_pkg::TIME_BITS'(off_act);
    assign t_acc_miss = now_time + dopc_pkg::TIME_BITS'(off_acc);
    assign t_acc_hit  = now_time + dopc_pkg::TIME_BITS'(cfg.t_rcd);

    always_comb begin
        r_pre = '0;
        r_act = '0;
        r_acc = '0;
        r_pre.dram_command  = dopc_pkg::CMD_PRE;
        r_pre.bank_group    = bg;
        r_pre.bank_index    = bk;
        r_act.dram_command  = dopc_pkg::CMD_ACT;
        r_act.bank_group    = bg;
        r_act.bank_index    = bk;
        r_act.row_or_column = row_rc;
        r_acc.dram_command  = acc;
        r_acc.bank_group    = bg;
        r_acc.bank_index    = bk;
        r_acc.row_or_column = col_rc;
        r_acc.last_of_request = 1'b1;

        plan = '0;
        plan.next_open.valid    = 1'b1;
        plan.next_open.bank     = bk;
        plan.next_open.row      = row;
        plan.next_open.act_time = open_st.act_time;

        if (dopc_pkg::req_t'(command) == dopc_pkg::REQ_INVALID) begin
            plan.count     = '0;
            plan.upd       = 1'b0;
            plan.next_open = open_st;
        end else if (cfg.simple_mode) begin
            r_acc.issue_time  = now_time;
            r_acc.busy_cycles = dopc_pkg::SIMPLE_CYCLES;
            plan.res[0]       = r_acc;
            plan.count        = dopc_pkg::CNT_W'(1);
            plan.upd          = 1'b0;
            plan.next_open    = open_st;
        end else if (row_hit && (bk == open_st.bank)) begin
            // page hit
            r_acc.issue_time  = now_time;
            r_acc.busy_cycles = dopc_pkg::BUSY_W'(cas_burst);
            plan.res[0]       = r_acc;
            plan.count        = dopc_pkg::CNT_W'(1);
            plan.upd          = 1'b1;
        end else if (row_hit) begin
            // same row, other bank: activate now
            r_act.issue_time  = now_time;
            r_acc.issue_time  = t_acc_hit;
            r_acc.busy_cycles = dopc_pkg::BUSY_W'(cfg.t_rcd) + dopc_pkg::BUSY_W'(cas_burst);
            plan.res[0]       = r_act;
            plan.res[1]       = r_acc;
            plan.count        = dopc_pkg::CNT_W'(2);
            plan.upd          = 1'b1;
            plan.next_open.act_time = now_time;
        end else begin
            r_pre.issue_time  = t_pre;
            r_act.issue_time  = t_act;
            r_acc.issue_time  = t_acc_miss;
            r_acc.busy_cycles = dopc_pkg::BUSY_W'(off_acc) + dopc_pkg::BUSY_W'(cas_burst);
            plan.res[0]       = r_pre;
            plan.res[1]       = r_act;
            plan.res[2]       = r_acc;
            plan.count        = dopc_pkg::CNT_W'(3);
            plan.upd          = 1'b1;
            plan.next_open.act_time = t_act;
        end
    end

endmodule

[rtl/dopc_out_seq.sv]
// ----------------------------------------------------------------------------
// dopc_out_seq
// Command buffer: holds one request's commands and shifts them out one item
// per accepted transfer.
// ----------------------------------------------------------------------------
module dopc_out_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  dopc_pkg::plan_t   plan,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dopc_pkg::result_t head
);

    dopc_pkg::result_t [dopc_pkg::MAX_CMDS-1:0] buf_reg, buf_next;
    logic [dopc_pkg::CNT_W-1:0]                cnt_reg, cnt_next;
    logic                                      take;

    assign m_tvalid = (cnt_reg != '0);
    assign take     = m_tvalid && m_tready;
    assign free     = (cnt_reg == '0) || (take && (cnt_reg == dopc_pkg::CNT_W'(1)));
    assign head     = buf_reg[0];

    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load) begin
            buf_next = plan.res;
            cnt_next = plan.count;
        end else if (take) begin
            for (int i = 0; i < dopc_pkg::MAX_CMDS - 1; i++) begin
                buf_next[i] = buf_reg[i+1];
            end
            cnt_next = cnt_reg - dopc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/dram_open_page_command_generator.sv]
// ----------------------------------------------------------------------------
// dram_open_page_command_generator
// Open-page DRAM command generator: one request in, PRE/ACT/access out.
// ----------------------------------------------------------------------------
// The first command of a request passes the input register, then the buffer.
// Each request yields 0..3 commands; the single command buffer drains one item
//   per cycle while m_tready is high; the input register buffers one request.
// Reset: synchronous, active low; timing registers return to defaults
//   (tRAS 52, tRCD/tRP/tCAS 24, burst 4, simple mode off), no row open.
module dram_open_page_command_generator (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // address[32:0], now_time[64:33], zero pad
    input  logic [1:0]  s_tuser,   // command

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // issue_time[31:0], bank_group[33:32],
                                   // bank_index[35:34], row_or_column[50:36],
                                   // busy_cycles[61:51], zero pad
    output logic [1:0]  m_tuser,   // dram_command
    output logic        m_tlast,   // last_of_request

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    localparam int TW = dopc_pkg::TIME_BITS;
    localparam int AW = dopc_pkg::ADDRESS_BITS;

    dopc_pkg::cfg_t          cfg_reg;
    dopc_pkg::open_t         open_reg;
    logic                    in_valid_reg;
    logic [1:0]              in_cmd_reg;
    logic [AW-1:0]           in_addr_reg;
    logic [TW-1:0]           in_now_reg;
    logic                    seq_free;
    logic                    proceed;
    logic                    s_take;
    dopc_pkg::plan_t         plan;
    dopc_pkg::result_t       head;

    assign proceed  = in_valid_reg && seq_free;
    assign s_tready = !in_valid_reg || seq_free;
    assign s_take   = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.t_ras       <= 8'd52;
            cfg_reg.t_rcd       <= 8'd24;
            cfg_reg.t_rp        <= 8'd24;
            cfg_reg.t_cas       <= 8'd24;
            cfg_reg.t_burst     <= 8'd4;
            cfg_reg.simple_mode <= 1'b0;
        end else if (cfg_wr_en) begin
            case (dopc_pkg::cfg_idx_t'(cfg_addr))
                dopc_pkg::CFG_T_RAS:   cfg_reg.t_ras       <= cfg_wdata;
                dopc_pkg::CFG_T_RCD:   cfg_reg.t_rcd       <= cfg_wdata;
                dopc_pkg::CFG_T_RP:    cfg_reg.t_rp        <= cfg_wdata;
                dopc_pkg::CFG_T_CAS:   cfg_reg.t_cas       <= cfg_wdata;
                dopc_pkg::CFG_T_BURST: cfg_reg.t_burst     <= cfg_wdata;
                dopc_pkg::CFG_SIMPLE:  cfg_reg.simple_mode <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_cmd_reg  <= s_tuser;
            in_addr_reg <= s_tdata[AW-1:0];
            in_now_reg  <= s_tdata[AW+TW-1:AW];
        end
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (proceed) begin
            in_valid_reg <= 1'b0;
        end
    end

    dopc_plan u_plan (
        .command  (in_cmd_reg),
        .address  (in_addr_reg),
        .now_time (in_now_reg),
        .cfg      (cfg_reg),
        .open_st  (open_reg),
        .plan     (plan)
    );

    // open-row tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else if (proceed && plan.upd) begin
            open_reg <= plan.next_open;
        end
    end

    dopc_out_seq u_out_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (proceed),
        .plan     (plan),
        .free     (seq_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = {2'b00, head.busy_cycles, head.row_or_column,
                      head.bank_index, head.bank_group, head.issue_time};
    assign m_tuser = head.dram_command;
    assign m_tlast = head.last_of_request;

endmodule

[sim/tb_dram_open_page_command_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dram_open_page_command_generator
// Self-checking bench for the open-page command generator. A short table of
// directed requests covers hits, bank switches, misses inside and after tRAS,
// timestamp wrap, invalid requests, simple mode and the timing extremes.
// Random phases follow, each with a fresh timing setup and one of four mixes
// of sender gaps and receiver stalls. Every command is checked against an
// in-bench model of the open-row tracker.
// ----------------------------------------------------------------------------
module tb_dram_open_page_command_generator;

    localparam int NUM_DIR      = 31;
    localparam int NUM_PHASES   = 8;
    localparam int ITEMS_PER_PH = 10;
    localparam int SETTLE_CYC   = 12;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic { STEP_REQ, STEP_CFG } step_kind_t;

    typedef enum logic [1:0] {
        IDLE_NONE     = 2'd0,
        IDLE_SENDER   = 2'd1,
        IDLE_RECEIVER = 2'd2,
        IDLE_BOTH     = 2'd3
    } idle_t;

    typedef struct packed {
        step_kind_t          step;
        dopc_pkg::cfg_idx_t  idx;
        logic [7:0]          val;
        dopc_pkg::req_t      kind;
        logic [32:0]         addr;
        logic [31:0]         now;
        logic                typed;      // exp_time / exp_busy hold the final command
        logic [31:0]         exp_time;
        logic [10:0]         exp_busy;
    } stim_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [7:0]  cfg_wdata = '0;

    // timing setup and open-row state as the block should hold them
    logic [7:0]                 cfg_ras    = 8'd52;
    logic [7:0]                 cfg_rcd    = 8'd24;
    logic [7:0]                 cfg_rp     = 8'd24;
    logic [7:0]                 cfg_cas    = 8'd24;
    logic [7:0]                 cfg_burst  = 8'd4;
    logic                       cfg_simple = 1'b0;
    logic                       open_vld   = 1'b0;
    logic [1:0]                 open_bk    = '0;
    logic [dopc_pkg::ROW_W-1:0] open_row   = '0;
    logic [31:0]                act_time   = '0;

    dopc_pkg::result_t cmds_due [$];
    idle_t             idle_mode    = IDLE_NONE;
    int                mismatches   = 0;
    int                stall_cycles = 0;
    stim_row_t         dir_rows [NUM_DIR];

    dram_open_page_command_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic stim_row_t req_row(dopc_pkg::req_t kind, logic [32:0] addr,
                                          logic [31:0] now, logic typed,
                                          logic [31:0] t, logic [10:0] busy);
        return '{STEP_REQ, dopc_pkg::CFG_T_RAS, 8'd0, kind, addr, now, typed, t, busy};
    endfunction

    function automatic stim_row_t cfg_row(dopc_pkg::cfg_idx_t idx, logic [7:0] val);
        return '{STEP_CFG, idx, val, dopc_pkg::REQ_READ, 33'd0, 32'd0, 1'b0, 32'd0, 11'd0};
    endfunction

    function automatic dopc_pkg::result_t make_cmd(logic [31:0] t, dopc_pkg::dram_cmd_t c,
                                                   logic [1:0] bg, logic [1:0] bk,
                                                   logic [14:0] rc, logic last,
                                                   logic [10:0] busy);
        dopc_pkg::result_t r;
        r.issue_time      = t;
        r.dram_command    = c;
        r.bank_group      = bg;
        r.bank_index      = bk;
        r.row_or_column   = rc;
        r.last_of_request = last;
        r.busy_cycles     = busy;
        return r;
    endfunction

    // Expands one request into its PRE/ACT/access commands and updates the open row.
    function automatic void plan_dram_cmds(dopc_pkg::req_t kind, logic [32:0] addr,
                                           logic [31:0] now);
        logic [1:0]                 bg;
        logic [1:0]                 bk;
        logic [dopc_pkg::ROW_W-1:0] row;
        logic [14:0]                col;
        logic [31:0]                off;
        logic [31:0]                elapsed;
        logic [31:0]                ras_wait;
        dopc_pkg::dram_cmd_t        acc;
        if (kind == dopc_pkg::REQ_INVALID)
            return;
        bg  = addr[7:6];
        bk  = addr[9:8];
        row = addr[32:18];
        col = {4'd0, addr[17:10], addr[5:3]};
        acc = (kind == dopc_pkg::REQ_WRITE) ? dopc_pkg::CMD_WR : dopc_pkg::CMD_RD;
        off = '0;
        if (cfg_simple) begin
            cmds_due.push_back(make_cmd(now, acc, bg, bk, col, 1'b1,
                                        dopc_pkg::SIMPLE_CYCLES));
            return;
        end
        // bank group is deliberately not part of the hit test
        if (open_vld && row == open_row) begin
            if (bk != open_bk) begin
                cmds_due.push_back(make_cmd(now, dopc_pkg::CMD_ACT, bg, bk, 15'(row),
                                            1'b0, 11'd0));
                act_time = now;
                off      = off + cfg_rcd;
            end
        end else begin
            ras_wait = '0;
            if (open_vld) begin
                elapsed = now - act_time;
                if (elapsed < {24'd0, cfg_ras})
                    ras_wait = {24'd0, cfg_ras} - elapsed;
            end
            off = off + ras_wait;
            cmds_due.push_back(make_cmd(now + off, dopc_pkg::CMD_PRE, bg, bk, 15'd0,
                                        1'b0, 11'd0));
            off = off + cfg_rp;
            cmds_due.push_back(make_cmd(now + off, dopc_pkg::CMD_ACT, bg, bk, 15'(row),
                                        1'b0, 11'd0));
            act_time = now + off;
            off      = off + cfg_rcd;
        end
        cmds_due.push_back(make_cmd(now + off, acc, bg, bk, col, 1'b1,
                                    dopc_pkg::BUSY_W'(off + cfg_cas + cfg_burst)));
        open_vld = 1'b1;
        open_bk  = bk;
        open_row = row;
    endfunction

    function automatic bit tx_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 56;
            IDLE_BOTH:   return $urandom_range(0, 99) < 9;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit rx_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 56;
            IDLE_BOTH:     return $urandom_range(0, 99) < 9;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] pick_timing();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // tvalid is left high after an accept so back-to-back items need no re-raise
    task automatic send_req(dopc_pkg::req_t kind, logic [32:0] addr, logic [31:0] now);
        @(negedge aclk);
        while (tx_idles()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, now, addr};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        plan_dram_cmds(kind, addr, now);
    endtask

    // invalid requests leave nothing queued, so settle covers any still in flight
    task automatic drain(int settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (cmds_due.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic cfg_write(dopc_pkg::cfg_idx_t idx, logic [7:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            dopc_pkg::CFG_T_RAS:   cfg_ras    = val;
            dopc_pkg::CFG_T_RCD:   cfg_rcd    = val;
            dopc_pkg::CFG_T_RP:    cfg_rp     = val;
            dopc_pkg::CFG_T_CAS:   cfg_cas    = val;
            dopc_pkg::CFG_T_BURST: cfg_burst  = val;
            dopc_pkg::CFG_SIMPLE:  cfg_simple = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic report_mismatch(string what, dopc_pkg::result_t want,
                                   dopc_pkg::result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s: exp t=%h cmd=%0d bg=%0d bk=%0d rc=%h last=%b busy=%0d",
                     what, want.issue_time, want.dram_command, want.bank_group,
                     want.bank_index, want.row_or_column, want.last_of_request,
                     want.busy_cycles);
            $display("    got t=%h cmd=%0d bg=%0d bk=%0d rc=%h last=%b busy=%0d",
                     got.issue_time, got.dram_command, got.bank_group,
                     got.bank_index, got.row_or_column, got.last_of_request,
                     got.busy_cycles);
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= !rx_stalls();
    end

    always @(posedge aclk) begin : cmd_monitor
        dopc_pkg::result_t got;
        dopc_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.issue_time      = m_tdata[31:0];
            got.dram_command    = dopc_pkg::dram_cmd_t'(m_tuser);
            got.bank_group      = m_tdata[33:32];
            got.bank_index      = m_tdata[35:34];
            got.row_or_column   = m_tdata[50:36];
            got.last_of_request = m_tlast;
            got.busy_cycles     = m_tdata[61:51];
            if (cmds_due.size() == 0) begin
                report_mismatch("unexpected command", '0, got);
            end else begin
                want = cmds_due.pop_front();
                if (got !== want)
                    report_mismatch("command mismatch", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_dram_open_page_command_generator failed");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t      st;
        logic [32:0]    addr;
        logic [31:0]    now_base;
        dopc_pkg::req_t kind;
        int             sent;

        dir_rows = '{
            // reset timing, nothing open: plain miss
            req_row(dopc_pkg::REQ_READ, 33'h0_0000_0000, 32'd1000, 1'b1, 32'd1048, 11'd76),
            req_row(dopc_pkg::REQ_WRITE, 33'h0_0003_FC38, 32'd1100, 1'b1, 32'd1100, 11'd28),
            // other bank group, same bank and row: still a hit
            req_row(dopc_pkg::REQ_FETCH, 33'h0_0000_00C0, 32'd1200, 1'b1, 32'd1200, 11'd28),
            req_row(dopc_pkg::REQ_READ, 33'h0_0000_0300, 32'd1300, 1'b1, 32'd1324, 11'd52),
            req_row(dopc_pkg::REQ_INVALID, 33'h1_2345_6789, 32'd1310, 1'b0, 32'd0, 11'd0),
            // miss inside tRAS of the last ACT waits out tRAS
            req_row(dopc_pkg::REQ_READ, 33'h0_0004_0000, 32'd1310, 1'b1, 32'd1400, 11'd118),
            req_row(dopc_pkg::REQ_WRITE, 33'h1_FFFF_FFFF, 32'hFFFF_FFF0, 1'b1,
                    32'h0000_0020, 11'd76),
            req_row(dopc_pkg::REQ_READ, 33'h1_FFFC_0300, 32'd0, 1'b1, 32'd0, 11'd28),
            req_row(dopc_pkg::REQ_READ, 33'h0_0008_0000, 32'd4, 1'b1, 32'd52, 11'd76),
            req_row(dopc_pkg::REQ_READ, 33'h0_000C_0000, 32'hFFFF_FFE0, 1'b1,
                    32'h0000_0010, 11'd76),
            // elapsed time measured across the 32-bit wrap
            req_row(dopc_pkg::REQ_WRITE, 33'h0_0010_0000, 32'd16, 1'b1, 32'd92, 11'd104),
            cfg_row(dopc_pkg::CFG_SIMPLE, 8'd1),
            req_row(dopc_pkg::REQ_READ, 33'h1_5555_5555, 32'd500, 1'b1, 32'd500, 11'd5),
            req_row(dopc_pkg::REQ_WRITE, 33'h0_AAAA_AAAA, 32'hFFFF_FFFF, 1'b1,
                    32'hFFFF_FFFF, 11'd5),
            req_row(dopc_pkg::REQ_FETCH, 33'h0_0000_0000, 32'd0, 1'b1, 32'd0, 11'd5),
            req_row(dopc_pkg::REQ_INVALID, 33'h1_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                    32'd0, 11'd0),
            cfg_row(dopc_pkg::CFG_SIMPLE,  8'd0),
            cfg_row(dopc_pkg::CFG_T_RAS,   8'hFF),
            cfg_row(dopc_pkg::CFG_T_RCD,   8'hFF),
            cfg_row(dopc_pkg::CFG_T_RP,    8'hFF),
            cfg_row(dopc_pkg::CFG_T_CAS,   8'hFF),
            cfg_row(dopc_pkg::CFG_T_BURST, 8'hFF),
            // open row untouched by simple mode, ACT still at 68
            req_row(dopc_pkg::REQ_READ, 33'h0_0014_0000, 32'd100, 1'b1, 32'd833, 11'd1243),
            req_row(dopc_pkg::REQ_WRITE, 33'h0_0014_0200, 32'd2000, 1'b1, 32'd2255, 11'd765),
            cfg_row(dopc_pkg::CFG_T_RAS,   8'd0),
            cfg_row(dopc_pkg::CFG_T_RCD,   8'd0),
            cfg_row(dopc_pkg::CFG_T_RP,    8'd0),
            cfg_row(dopc_pkg::CFG_T_CAS,   8'd0),
            cfg_row(dopc_pkg::CFG_T_BURST, 8'd0),
            req_row(dopc_pkg::REQ_READ, 33'h0_0018_0000, 32'd3000, 1'b1, 32'd3000, 11'd0),
            req_row(dopc_pkg::REQ_FETCH, 33'h0_0018_0008, 32'd3001, 1'b1, 32'd3001, 11'd0)
        };

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            st = dir_rows[i];
            if (st.step == STEP_CFG) begin
                drain(SETTLE_CYC);
                cfg_write(st.idx, st.val);
            end else begin
                send_req(st.kind, st.addr, st.now);
                if (st.typed) begin
                    cmds_due[cmds_due.size()-1].issue_time  = st.exp_time;
                    cmds_due[cmds_due.size()-1].busy_cycles = st.exp_busy;
                end
            end
        end

        now_base = 32'd5000;
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain(SETTLE_CYC);
            cfg_write(dopc_pkg::CFG_T_RAS,   pick_timing());
            cfg_write(dopc_pkg::CFG_T_RCD,   pick_timing());
            cfg_write(dopc_pkg::CFG_T_RP,    pick_timing());
            cfg_write(dopc_pkg::CFG_T_CAS,   pick_timing());
            cfg_write(dopc_pkg::CFG_T_BURST, pick_timing());
            cfg_write(dopc_pkg::CFG_SIMPLE,  8'($urandom_range(0, 3) == 0));
            idle_mode = idle_t'(p % 4);
            sent = 0;
            while (sent < ITEMS_PER_PH) begin
                // bias toward the open row so hits and bank switches are common
                addr = {1'($urandom_range(0, 1)), 32'($urandom())};
                case ($urandom_range(0, 4))
                    0, 1: begin
                        addr[32:18] = open_row;
                        addr[9:8]   = open_bk;
                    end
                    2: addr[32:18] = open_row;
                    default: ;
                endcase
                if ($urandom_range(0, 6) == 0)
                    now_base = $urandom();
                else
                    now_base = now_base + $urandom_range(0, 80);
                kind = ($urandom_range(0, 11) == 0) ? dopc_pkg::REQ_INVALID
                                                    : dopc_pkg::req_t'($urandom_range(0, 2));
                send_req(kind, addr, now_base);
                if (kind != dopc_pkg::REQ_INVALID)
                    sent++;
                if (p == 1 && sent == ITEMS_PER_PH / 2)
                    drain(0);
            end
        end

        drain(SETTLE_CYC);
        if (mismatches == 0 && cmds_due.size() == 0)
            $display("tb_dram_open_page_command_generator passed");
        else
            $display("tb_dram_open_page_command_generator failed");
        $finish;
    end

endmodule
